// File: design/phsq_pkg.sv
// Shared types and constants for the peak-and-hold solenoid sequencer.
// Beat structs, phase codes and period timing constants; no dependencies.
package phsq_pkg;

    localparam int unsigned DUTY_W  = 13;
    localparam int unsigned TICKS_W = 17;
    localparam int unsigned PROD_W  = 25;

    localparam logic [DUTY_W-1:0]  START_LEVEL  = 13'd224;
    localparam logic [DUTY_W-1:0]  SKIP_LEVEL   = 13'd3220;
    localparam logic [DUTY_W-1:0]  FULL_DUTY    = 13'd4096;
    localparam logic [TICKS_W-1:0] INRUSH_MAX   = 17'd15000;
    localparam logic [TICKS_W-1:0] PERIOD_TICKS = 17'd100000;

    // on-time = duty * 50000 / 4096 = (duty * 3125) >> 8
    localparam logic [PROD_W-1:0]  ON_SCALE     = 25'd3125;
    localparam int unsigned        ON_SHIFT     = 8;

    localparam logic FUNC_SET_DUTY = 1'b0;
    localparam logic FUNC_ALARM    = 1'b1;

    typedef enum logic [2:0] {
        PH_OFF       = 3'b001,
        PH_HOLD_NEXT = 3'b010,
        PH_OFF_NEXT  = 3'b100
    } phase_t;

    typedef struct packed {
        logic              func;
        logic [DUTY_W-1:0] duty;
    } in_beat_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  drive_duty;
        logic [TICKS_W-1:0] next_interval;
    } out_beat_t;

endpackage

// File: design/peak_hold_solenoid_sequencer.sv
// Peak-and-hold solenoid sequencer: top level with phase logic and result register.
// Depends on phsq_pkg for beat structs, phase codes and timing constants.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): a set-duty beat (func = 0) stores the
//     duty, saturated to 4096, and derives inrush, hold and off times of one
//     100000-tick period. It yields no result. An alarm beat (func = 1) yields one
//     result: the duty to drive and the ticks until the next alarm.
//   out channel (out_valid/out_ready/out_data): one result per alarm, in order.
//   cfg port (cfg_we/cfg_wdata): writes hold_duty; write when idle.
// Latency: a result is valid the cycle after its alarm beat is accepted.
// Throughput: one beat per cycle while in_ready is high; the phase update and
//   the on-time product (one constant multiply) sit combinationally between the
//   input handshake and the registers.
// Stall: while a result waits and out_ready is low, in_ready drops; it stays
//   high whenever the result register is empty or is being drained.
// Reset: all times, duty and hold_duty clear to zero, phase returns to off,
//   the result register is emptied.
module peak_hold_solenoid_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  phsq_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output phsq_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic [phsq_pkg::DUTY_W-1:0] cfg_wdata
);

    logic [phsq_pkg::DUTY_W-1:0]  hold_duty_reg;
    logic [phsq_pkg::DUTY_W-1:0]  duty_level_reg,   duty_level_next;
    logic [phsq_pkg::TICKS_W-1:0] inrush_reg,       inrush_next;
    logic [phsq_pkg::TICKS_W-1:0] hold_reg,         hold_next;
    logic [phsq_pkg::TICKS_W-1:0] off_reg,          off_next;
    logic [phsq_pkg::TICKS_W-1:0] cyc_inrush_reg,   cyc_inrush_next;
    logic [phsq_pkg::TICKS_W-1:0] cyc_hold_reg,     cyc_hold_next;
    logic [phsq_pkg::TICKS_W-1:0] cyc_off_reg,      cyc_off_next;
    phsq_pkg::phase_t             phase_reg,        phase_next;
    logic                         out_valid_reg,    out_valid_next;
    phsq_pkg::out_beat_t          out_data_reg,     out_data_next;

    logic                         in_fire;
    logic [phsq_pkg::DUTY_W-1:0]  duty_sat;
    logic [phsq_pkg::DUTY_W-1:0]  hold_sat;
    logic [phsq_pkg::PROD_W-1:0]  on_prod;
    logic [phsq_pkg::TICKS_W-1:0] on_ticks;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign duty_sat = (in_data.duty > phsq_pkg::FULL_DUTY) ? phsq_pkg::FULL_DUTY
                                                          : in_data.duty;
    assign hold_sat = (hold_duty_reg > phsq_pkg::FULL_DUTY) ? phsq_pkg::FULL_DUTY
                                                           : hold_duty_reg;
    assign on_prod  = phsq_pkg::PROD_W'(duty_sat) * phsq_pkg::ON_SCALE;
    assign on_ticks = on_prod[phsq_pkg::ON_SHIFT +: phsq_pkg::TICKS_W];

    always_comb
    begin
        duty_level_next = duty_level_reg;
        inrush_next     = inrush_reg;
        hold_next       = hold_reg;
        off_next        = off_reg;
        cyc_inrush_next = cyc_inrush_reg;
        cyc_hold_next   = cyc_hold_reg;
        cyc_off_next    = cyc_off_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        if (in_fire && (in_data.func == phsq_pkg::FUNC_SET_DUTY))
        begin
            duty_level_next = duty_sat;
            if (on_ticks > phsq_pkg::INRUSH_MAX)
            begin
                inrush_next = phsq_pkg::INRUSH_MAX;
                hold_next   = on_ticks - phsq_pkg::INRUSH_MAX;
            end
            else
            begin
                inrush_next = on_ticks;
                hold_next   = '0;
            end
            off_next = phsq_pkg::PERIOD_TICKS - on_ticks;
        end
        else if (in_fire)
        begin
            out_valid_next = 1'b1;
            if (duty_level_reg < phsq_pkg::START_LEVEL)
            begin
                out_data_next.drive_duty    = '0;
                out_data_next.next_interval = phsq_pkg::PERIOD_TICKS;
            end
            else if (duty_level_reg > phsq_pkg::SKIP_LEVEL)
            begin
                out_data_next.drive_duty    = hold_sat;
                out_data_next.next_interval = phsq_pkg::PERIOD_TICKS;
            end
            else
            begin
                unique case (phase_reg)
                    phsq_pkg::PH_OFF:
                    begin
                        cyc_inrush_next = inrush_reg;
                        cyc_hold_next   = hold_reg;
                        cyc_off_next    = off_reg;
                        out_data_next.drive_duty    = phsq_pkg::FULL_DUTY;
                        out_data_next.next_interval = inrush_reg;
                        phase_next = (hold_reg == '0) ? phsq_pkg::PH_OFF_NEXT
                                                      : phsq_pkg::PH_HOLD_NEXT;
                    end
                    phsq_pkg::PH_HOLD_NEXT:
                    begin
                        out_data_next.drive_duty    = hold_sat;
                        out_data_next.next_interval = cyc_hold_reg;
                        phase_next = phsq_pkg::PH_OFF_NEXT;
                    end
                    default:
                    begin
                        out_data_next.drive_duty    = '0;
                        out_data_next.next_interval = cyc_off_reg;
                        phase_next = phsq_pkg::PH_OFF;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_duty_reg  <= '0;
            duty_level_reg <= '0;
            inrush_reg     <= '0;
            hold_reg       <= '0;
            off_reg        <= '0;
            cyc_inrush_reg <= '0;
            cyc_hold_reg   <= '0;
            cyc_off_reg    <= '0;
            phase_reg      <= phsq_pkg::PH_OFF;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hold_duty_reg <= cfg_wdata;
            end
            duty_level_reg <= duty_level_next;
            inrush_reg     <= inrush_next;
            hold_reg       <= hold_next;
            off_reg        <= off_next;
            cyc_inrush_reg <= cyc_inrush_next;
            cyc_hold_reg   <= cyc_hold_next;
            cyc_off_reg    <= cyc_off_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_alarm_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_data.func == phsq_pkg::FUNC_ALARM) |=> out_valid_reg)
        else $error("alarm beat did not load a result");

    a_set_duty_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_data.func == phsq_pkg::FUNC_SET_DUTY) && out_ready
        |=> !out_valid_reg)
        else $error("set-duty beat produced a result");

    a_inrush_capped: assert property (@(posedge clk) disable iff (!rst_n)
        inrush_reg <= phsq_pkg::INRUSH_MAX)
        else $error("inrush time above cap");

    a_hold_after_full_inrush: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg != '0) |-> (inrush_reg == phsq_pkg::INRUSH_MAX))
        else $error("hold time without full inrush");

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.drive_duty <= phsq_pkg::FULL_DUTY))
        else $error("drive duty above full scale");
`endif

endmodule
